// ----- design/sas_pkg.sv -----
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the SPI ADC channel scanner
// Opcodes, result kinds, frame phase codes and the result beat layout.
// ----------------------------------------------------------------------------
package sas_pkg;

  // input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_CMD      = 2'd0;
  localparam logic [1:0] KIND_STORED   = 2'd1;
  localparam logic [1:0] KIND_OVERRUN  = 2'd2;
  localparam logic [1:0] KIND_READBACK = 2'd3;

  // frame phase codes
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_IDLE   = 2'd2;

  localparam logic [15:0] READING_MASK     = 16'h03FF;
  localparam logic [15:0] SINGLE_ENDED_BIT = 16'h8000;
  localparam int          CHANNEL_SHIFT    = 12;
  localparam logic [15:0] START_WORD       = 16'h0001;
  localparam logic [15:0] NO_READING       = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [2:0]  channel;
    logic        chip_select;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

// ----- design/sas_core.sv -----
// ----------------------------------------------------------------------------
// sas_core: scan state and result generation
// Holds frame phase, scan channel, select, overrun count and the readings;
// turns one accepted beat into up to two result beats.
// ----------------------------------------------------------------------------
module sas_core #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic [15:0]         rx_word,
  input  logic [2:0]          read_channel,
  output sas_pkg::push_t      push
);

  localparam logic [3:0] CH_COUNT = 4'(CHANNELS);

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  scan_r, scan_nxt;
  logic        selected_r, selected_nxt;
  logic [15:0] overrun_r, overrun_nxt;
  logic [15:0] readings_r [CHANNELS];
  logic        rd_wr_en;
  logic [15:0] rd_data;
  logic [15:0] stored_val;
  logic [15:0] cmd_word;
  logic [3:0]  scan_inc;

  assign stored_val = rx_word & sas_pkg::READING_MASK;
  assign cmd_word   = sas_pkg::SINGLE_ENDED_BIT | (16'(scan_r) << sas_pkg::CHANNEL_SHIFT);
  assign scan_inc   = {1'b0, scan_r} + 4'd1;
  assign rd_data    = ({1'b0, read_channel} < CH_COUNT) ? readings_r[read_channel]
                                                        : sas_pkg::NO_READING;

  always_comb begin
    phase_nxt    = phase_r;
    scan_nxt     = scan_r;
    selected_nxt = selected_r;
    overrun_nxt  = overrun_r;
    rd_wr_en     = 1'b0;
    push         = '0;
    if (accept) begin
      unique case (opcode)
        sas_pkg::OP_TICK: begin
          if (phase_r != sas_pkg::PHASE_IDLE && overrun_r != sas_pkg::COUNT_MAX) begin
            overrun_nxt = overrun_r + 16'd1;
          end
          selected_nxt = 1'b1;
          phase_nxt    = sas_pkg::PHASE_FIRST;
          push.push0   = 1'b1;
          push.res0    = '{sas_pkg::KIND_CMD, sas_pkg::START_WORD, scan_r, 1'b1, 1'b0};
          push.push1   = 1'b1;
          push.res1    = '{sas_pkg::KIND_CMD, cmd_word, scan_r, 1'b1, 1'b1};
        end
        sas_pkg::OP_WORD: begin
          if (phase_r == sas_pkg::PHASE_FIRST) begin
            phase_nxt = sas_pkg::PHASE_SECOND;   // first word only advances the phase, no beat
          end else begin
            phase_nxt    = sas_pkg::PHASE_IDLE;
            rd_wr_en     = 1'b1;
            selected_nxt = 1'b0;
            scan_nxt     = (scan_inc >= CH_COUNT) ? 3'd0 : scan_inc[2:0];
            push.push0   = 1'b1;
            push.res0    = '{sas_pkg::KIND_STORED, stored_val, scan_r, 1'b0, 1'b1};
          end
        end
        sas_pkg::OP_FETCH: begin
          overrun_nxt = '0;
          push.push0  = 1'b1;
          push.res0   = '{sas_pkg::KIND_OVERRUN, overrun_r, 3'd0, selected_r, 1'b1};
        end
        sas_pkg::OP_READ: begin
          push.push0 = 1'b1;
          push.res0  = '{sas_pkg::KIND_READBACK, rd_data, read_channel, selected_r, 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sas_pkg::PHASE_IDLE;
      scan_r     <= '0;
      selected_r <= 1'b0;
      overrun_r  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        readings_r[i] <= sas_pkg::NO_READING;
      end
    end else begin
      phase_r    <= phase_nxt;
      scan_r     <= scan_nxt;
      selected_r <= selected_nxt;
      overrun_r  <= overrun_nxt;
      if (rd_wr_en) begin
        readings_r[scan_r] <= stored_val;
      end
    end
  end

  // select only drops on a word that closes a frame
  a_sel_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(selected_r) |-> $past(accept && opcode == sas_pkg::OP_WORD))
    else $error("select released without a closing word");

  // overrun count only shrinks on a fetch
  a_ovr_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (overrun_r < $past(overrun_r))
      |-> $past(accept && opcode == sas_pkg::OP_FETCH))
    else $error("overrun count dropped without fetch");

  // scan channel stays in range
  a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, scan_r} < CH_COUNT)
    else $error("scan channel out of range");

endmodule

// ----- design/sas_fifo.sv -----
// ----------------------------------------------------------------------------
// sas_fifo: result queue
// Four-entry queue taking up to two result beats a cycle, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
module sas_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  sas_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output sas_pkg::result_t out_res
);

  sas_pkg::result_t              mem_r [sas_pkg::RQ_DEPTH];
  logic [sas_pkg::RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sas_pkg::RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sas_pkg::RQ_CNT_W-1:0] count_r, count_nxt;
  logic [sas_pkg::RQ_PTR_W-1:0] wr_ptr_p1;
  logic                          pop;
  logic [sas_pkg::RQ_CNT_W-1:0] n_push;

  assign wr_ptr_p1 = wr_ptr_r + sas_pkg::RQ_PTR_W'(1);
  assign pop       = out_valid && !out_stall;
  assign n_push    = sas_pkg::RQ_CNT_W'(push.push0) + sas_pkg::RQ_CNT_W'(push.push1);
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  // space for a two-beat item
  assign room      = (count_r <= sas_pkg::RQ_CNT_W'(sas_pkg::RQ_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + n_push[sas_pkg::RQ_PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + sas_pkg::RQ_PTR_W'(pop);
  assign count_nxt  = count_r + n_push - sas_pkg::RQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push0 || push.push1) |-> room)
    else $error("result queue overflow");

  a_push_ord: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second beat pushed without first");

endmodule

// ----- design/spi_adc_channel_scanner.sv -----
// ----------------------------------------------------------------------------
// spi_adc_channel_scanner: round-robin scan controller for an 8-channel SPI ADC
// An accepted beat's results are registered into the result queue, behind any older results.
// Throughput: one input beat a cycle while the queue has room; a tick yields two
// result beats, so the result side (one beat a cycle when not stalled) sets the
// sustained rate under tick-heavy load. A four-entry result queue lets input be
// taken while results wait. Reset (rst_n low, synchronous): idle frame, channel 0,
// deselected, no overruns, all readings 0xFFFF, queue empty.
// ----------------------------------------------------------------------------
module spi_adc_channel_scanner #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_rx_word,
  input  logic [2:0]  in_read_channel,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_data,
  output logic [2:0]  out_channel,
  output logic        out_chip_select,
  output logic        out_last
);

  logic             accept;
  logic             room;
  sas_pkg::push_t   push;
  sas_pkg::result_t out_res;

  // stall only when the queue cannot take a two-beat item
  assign in_stall = !room;
  assign accept   = in_valid && room;

  // state update and result build, one beat per cycle while not stalled
  sas_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_opcode),
    .rx_word      (in_rx_word),
    .read_channel (in_read_channel),
    .push         (push)
  );

  // result queue decouples the two sides
  sas_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_data        = out_res.data;
  assign out_channel     = out_res.channel;
  assign out_chip_select = out_res.chip_select;
  assign out_last        = out_res.last;

endmodule

// ----- sim/spi_adc_channel_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// spi_adc_channel_scanner_tb: self-checking bench for the SPI ADC scanner
// Drives opcode beats through the valid/stall input channel, predicts every
// result beat with a behavioural copy of the scan state, and checks the result
// channel field by field. Directed corner cases come first, then random
// well-formed frames mixed with broken frames and noise under three idling
// regimes, then a short tick burst that piles up overruns.
// ----------------------------------------------------------------------------
module spi_adc_channel_scanner_tb;

  localparam int SCAN_CHANNELS = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BEATS  = 1900;
  // ticks in a row with no frame ever finished
  localparam int BURST_TICKS   = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the scan state and a queue of the result
  // beats still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class scan_scoreboard;
    sas_pkg::result_t pending[$];
    logic [1:0]  phase;
    logic [15:0] held_word;
    logic [2:0]  scan_ch;
    logic [15:0] readings[SCAN_CHANNELS];
    logic [15:0] overruns;
    logic        selected;
    int unsigned errors;
    int unsigned checked;
    int unsigned stored;
    int unsigned peak_overruns;

    function new();
      phase     = sas_pkg::PHASE_IDLE;
      held_word = '0;
      scan_ch   = '0;
      overruns  = '0;
      selected  = 1'b0;
      foreach (readings[i]) readings[i] = sas_pkg::NO_READING;
      errors        = 0;
      checked       = 0;
      stored        = 0;
      peak_overruns = 0;
    endfunction

    function void queue_result(logic [1:0] kind, logic [15:0] data, logic [2:0] ch,
                               logic cs, logic last);
      sas_pkg::result_t r;
      r.kind        = kind;
      r.data        = data;
      r.channel     = ch;
      r.chip_select = cs;
      r.last        = last;
      pending.push_back(r);
    endfunction

    // Update the predicted state for one accepted input beat.
    function void note_beat(logic [1:0] op, logic [15:0] rx, logic [2:0] rc);
      logic [2:0]  ch;
      logic [15:0] val;
      ch = scan_ch;
      case (op)
        sas_pkg::OP_TICK: begin
          // a tick arriving mid-frame is an overrun; the count saturates
          if (phase != sas_pkg::PHASE_IDLE && overruns != sas_pkg::COUNT_MAX) overruns++;
          if (32'(overruns) > peak_overruns) peak_overruns = 32'(overruns);
          selected  = 1'b1;
          held_word = '0;
          phase     = sas_pkg::PHASE_FIRST;
          queue_result(sas_pkg::KIND_CMD, sas_pkg::START_WORD, ch, 1'b1, 1'b0);
          queue_result(sas_pkg::KIND_CMD,
                       sas_pkg::SINGLE_ENDED_BIT | (16'(ch) << sas_pkg::CHANNEL_SHIFT),
                       ch, 1'b1, 1'b1);
        end
        sas_pkg::OP_WORD: begin
          if (phase == sas_pkg::PHASE_FIRST) begin
            // first word of the frame is only held
            phase     = sas_pkg::PHASE_SECOND;
            held_word = rx;
          end else begin
            // second word, or any word while idle, completes a conversion
            phase        = sas_pkg::PHASE_IDLE;
            val          = rx & sas_pkg::READING_MASK;
            readings[ch] = val;
            selected     = 1'b0;
            scan_ch      = (int'(ch) + 1 >= SCAN_CHANNELS) ? 3'd0 : ch + 3'd1;
            stored++;
            queue_result(sas_pkg::KIND_STORED, val, ch, 1'b0, 1'b1);
          end
        end
        sas_pkg::OP_FETCH: begin
          queue_result(sas_pkg::KIND_OVERRUN, overruns, 3'd0, selected, 1'b1);
          overruns = '0;
        end
        default: begin
          queue_result(sas_pkg::KIND_READBACK,
                       (int'(rc) < SCAN_CHANNELS) ? readings[rc] : sas_pkg::NO_READING,
                       rc, selected, 1'b1);
        end
      endcase
    endfunction

    function void report_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_beat(sas_pkg::result_t got);
      sas_pkg::result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, got kind %0d data %h",
                 $time, got.kind, got.data);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.kind !== want.kind)
        report_field("kind", 16'(want.kind), 16'(got.kind));
      if (got.data !== want.data)
        report_field("data", want.data, got.data);
      if (got.channel !== want.channel)
        report_field("channel", 16'(want.channel), 16'(got.channel));
      if (got.chip_select !== want.chip_select)
        report_field("chip_select", 16'(want.chip_select), 16'(got.chip_select));
      if (got.last !== want.last)
        report_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = sas_pkg::OP_TICK;
  logic [15:0] in_rx_word = '0;
  logic [2:0]  in_read_channel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_data;
  logic [2:0]  out_channel;
  logic        out_chip_select;
  logic        out_last;

  scan_scoreboard sb;
  int unsigned    in_idle_pct  = 0;
  int unsigned    out_idle_pct = 0;
  int unsigned    beats_sent   = 0;
  int unsigned    cycles       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spi_adc_channel_scanner #(
    .CHANNELS (SCAN_CHANNELS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_rx_word      (in_rx_word),
    .in_read_channel (in_read_channel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_channel     (out_channel),
    .out_chip_select (out_chip_select),
    .out_last        (out_last)
  );

  // Watchdog: ends the run as failed once the cycle counter passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** spi_adc_channel_scanner: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure, redrawn every cycle; independent of out_valid.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Monitor: both channels are sampled at the same edge with pre-edge values.
  // Results land no sooner than the cycle after their input beat, so the
  // result check is done before the new input beat is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_beat(sas_pkg::result_t'{out_kind, out_data, out_channel,
                                         out_chip_select, out_last});
      if (in_valid && !in_stall)
        sb.note_beat(in_opcode, in_rx_word, in_read_channel);
    end
  end

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  // Offer one beat, with random idle cycles ahead of it, and hold it until the
  // block takes it. While valid is low the payload carries junk.
  task automatic send_beat(input logic [1:0] op, input logic [15:0] rx,
                           input logic [2:0] rc);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid        <= 1'b0;
      in_opcode       <= 2'($urandom);
      in_rx_word      <= 16'($urandom);
      in_read_channel <= 3'($urandom);
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_rx_word      <= rx;
    in_read_channel <= rc;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beats_sent++;
  endtask

  // unused fields get random content so every payload bit keeps moving
  task automatic do_tick();
    send_beat(sas_pkg::OP_TICK, 16'($urandom), 3'($urandom));
  endtask

  task automatic do_word(input logic [15:0] rx);
    send_beat(sas_pkg::OP_WORD, rx, 3'($urandom));
  endtask

  task automatic do_fetch();
    send_beat(sas_pkg::OP_FETCH, 16'($urandom), 3'($urandom));
  endtask

  task automatic do_read(input logic [2:0] rc);
    send_beat(sas_pkg::OP_READ, 16'($urandom), rc);
  endtask

  // A complete conversion: tick, two words, sometimes a query mid-frame.
  task automatic run_frame();
    do_tick();
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(1)) do_fetch();
      else do_read(3'($urandom));
    end
    do_word(16'($urandom));
    do_word(16'($urandom));
  endtask

  // Mostly well-formed frames; the rest is broken frames, queries and noise.
  task automatic run_random(input int unsigned n);
    int unsigned first;
    int unsigned pick;
    first = beats_sent;
    while (beats_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 65) run_frame();
      else if (pick < 75) begin
        // frame cut short: the next tick sees it unfinished
        do_tick();
        if ($urandom_range(1)) do_word(16'($urandom));
      end
      else if (pick < 83) do_fetch();
      else if (pick < 91) do_read(3'($urandom));
      else send_beat(2'($urandom), 16'($urandom), 3'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    in_idle_pct  = 33;
    out_idle_pct = 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads on fresh state return the no-reading marker, fetch a zero count
    do_read(3'd0);
    do_read(3'd7);
    do_fetch();
    // word with nothing in flight is taken as a second word (channel 0)
    do_word(16'hFFFF);
    // first tick after reset must not count an overrun
    do_tick();
    do_fetch();
    do_word(16'h0000);
    do_word(16'h0000);
    // query while selected reports chip select high
    do_tick();
    do_read(3'd1);
    do_word(16'hAAAA);
    do_read(3'd7);
    // tick on an unfinished frame counts an overrun, fetch clears it
    do_tick();
    do_tick();
    do_fetch();
    do_fetch();
    do_word(16'hFC00);
    do_word(16'h5555);
    do_read(3'd2);
    do_read(3'd0);

    // Random: sender-light / receiver-heavy idling, then swapped, then none
    run_random(RANDOM_BEATS / 3);
    in_idle_pct  = 78;
    out_idle_pct = 33;
    run_random(RANDOM_BEATS / 3);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

    // Overrun burst: clear the count, then tick without ever finishing a frame
    do_fetch();
    repeat (BURST_TICKS) do_tick();
    do_fetch();
    do_fetch();

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // keep clocking a while to catch any stray result beat
    repeat (16) @(posedge clk);

    $display("Run covered %0d input beats and %0d result beats checked,", beats_sent,
             sb.checked);
    $display("with %0d readings stored and overrun counts up to %0d.", sb.stored,
             sb.peak_overruns);
    if (sb.errors == 0) begin
      $display("** spi_adc_channel_scanner: PASSED **");
    end else begin
      $display("** spi_adc_channel_scanner: FAILED **");
    end
    $finish;
  end

endmodule
